// ----- hw/rtl/ctpg_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ctpg_pkg: shared types, constants and helpers of the circle trajectory
// generator. Phase constants are in Q24 radians.
// ----------------------------------------------------------------------------
package ctpg_pkg;

	localparam int unsigned CORDIC_STAGES_DEF = 16;
	localparam int unsigned CORDIC_STAGES_MAX = 24;

	localparam int unsigned OUT_W   = 20;
	localparam int unsigned CFG_W   = 20;
	localparam int unsigned CIDX_W  = 3;
	localparam int unsigned SAT_W   = 40;

	localparam logic [27:0] TWO_PI_Q24      = 28'd105414357;
	localparam logic signed [27:0] PI_Q24   = 28'sd52707179;
	localparam logic signed [27:0] HALF_PI_Q24 = 28'sd26353589;
	localparam logic signed [27:0] CORDIC_GAIN_Q24 = 28'sd10188014;

	typedef logic [CIDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_RADIUS    = 3'd0;
	localparam cfg_idx_t REG_RATE      = 3'd1;
	localparam cfg_idx_t REG_CENTER_X  = 3'd2;
	localparam cfg_idx_t REG_CENTER_Y  = 3'd3;
	localparam cfg_idx_t REG_CENTER_Z  = 3'd4;
	localparam cfg_idx_t REG_PLANE_COS = 3'd5;
	localparam cfg_idx_t REG_PLANE_SIN = 3'd6;

	localparam logic [18:0]        RADIUS_RST    = 19'd9830;
	localparam logic [19:0]        RATE_RST      = 20'd39322;
	localparam logic signed [19:0] CENTER_X_RST  = -20'sd36045;
	localparam logic signed [19:0] CENTER_Y_RST  = 20'sd0;
	localparam logic signed [19:0] CENTER_Z_RST  = 20'sd32768;
	localparam logic signed [17:0] PLANE_COS_RST = 18'sd65536;
	localparam logic signed [17:0] PLANE_SIN_RST = 18'sd0;

	typedef logic signed [OUT_W-1:0] out_t;

	// arctangent of 2^-i in Q24
	function automatic logic signed [27:0] atan_q24(input logic [4:0] i);
		logic signed [27:0] a;
		case (i)
			5'd0:  a = 28'sd13176795;
			5'd1:  a = 28'sd7778716;
			5'd2:  a = 28'sd4110060;
			5'd3:  a = 28'sd2086331;
			5'd4:  a = 28'sd1047214;
			5'd5:  a = 28'sd524117;
			5'd6:  a = 28'sd262123;
			5'd7:  a = 28'sd131069;
			5'd8:  a = 28'sd65536;
			5'd9:  a = 28'sd32768;
			5'd10: a = 28'sd16384;
			5'd11: a = 28'sd8192;
			5'd12: a = 28'sd4096;
			5'd13: a = 28'sd2048;
			5'd14: a = 28'sd1024;
			5'd15: a = 28'sd512;
			5'd16: a = 28'sd256;
			5'd17: a = 28'sd128;
			5'd18: a = 28'sd64;
			5'd19: a = 28'sd32;
			5'd20: a = 28'sd16;
			5'd21: a = 28'sd8;
			5'd22: a = 28'sd4;
			5'd23: a = 28'sd2;
			default: a = 28'sd0;
		endcase
		return a;
	endfunction

	function automatic out_t sat_out(input logic signed [SAT_W-1:0] v);
		out_t r;
		if (v > SAT_W'(signed'(20'sh7FFFF)))
			r = 20'sh7FFFF;
		else if (v < SAT_W'(signed'(20'sh80000)))
			r = 20'sh80000;
		else
			r = v[OUT_W-1:0];
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/circle_trajectory_point_gen_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// circle_trajectory_point_gen_top: circle trajectory point generator
//
// Command in: raise start with elapsed_time (unsigned Q16.16 s); the beat is
// taken at each clock edge where start is high and busy is low. busy is high
// in reset and up to the first clock edge after it, so from then on a new
// time sample can be taken in every cycle.
// Result out: done strobes for one cycle with pos, vel and acc (Q3.16,
// saturated) of the point on the tilted, offset circle. The receiver takes
// the beat at the edge that ends the cycle and cannot hold it off.
// Throughput: one sample per cycle, set by the pipeline: a multiplier stage,
// six stages of three-bit modulo reduction, a fold stage, one CORDIC stage
// per iteration and four multiply/round/saturate stages.
// Config: cfg_we writes cfg_wdata into register cfg_index at the clock edge;
// write only while no sample is in flight. Derived amplitudes settle through
// rw_q and then rww_q after a write. Reset clears the pipeline valid bits
// and loads the register defaults.
// ----------------------------------------------------------------------------
module circle_trajectory_point_gen_top
	import ctpg_pkg::*;
#(
	parameter int unsigned CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [31:0]        elapsed_time,
	input  wire logic               cfg_we,
	input  wire logic [CIDX_W-1:0]  cfg_index,
	input  wire logic [CFG_W-1:0]   cfg_wdata,
	output logic                    done,
	output logic signed [19:0]      pos_x,
	output logic signed [19:0]      pos_y,
	output logic signed [19:0]      pos_z,
	output logic signed [19:0]      vel_x,
	output logic signed [19:0]      vel_y,
	output logic signed [19:0]      vel_z,
	output logic signed [19:0]      acc_x,
	output logic signed [19:0]      acc_y,
	output logic signed [19:0]      acc_z
);

	localparam int unsigned CS = (CORDIC_STAGES > CORDIC_STAGES_MAX) ?
		CORDIC_STAGES_MAX : CORDIC_STAGES;
	localparam int unsigned MOD_BITS = 18;
	localparam int unsigned MOD_PER  = 3;
	localparam int unsigned MOD_ST   = MOD_BITS / MOD_PER;
	localparam int unsigned LAT      = CS + 12;

	// ---------------- configuration ----------------
	logic [18:0]        radius_q;
	logic [19:0]        rate_q;
	logic signed [19:0] center_x_q, center_y_q, center_z_q;
	logic signed [17:0] plane_cos_q, plane_sin_q;
	logic [23:0]        rw_q;
	logic [27:0]        rww_q;
	logic               busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q    <= RADIUS_RST;
			rate_q      <= RATE_RST;
			center_x_q  <= CENTER_X_RST;
			center_y_q  <= CENTER_Y_RST;
			center_z_q  <= CENTER_Z_RST;
			plane_cos_q <= PLANE_COS_RST;
			plane_sin_q <= PLANE_SIN_RST;
			busy_q      <= 1'b1;
		end else begin
			busy_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_RADIUS:    radius_q    <= cfg_wdata[18:0];
					REG_RATE:      rate_q      <= cfg_wdata;
					REG_CENTER_X:  center_x_q  <= signed'(cfg_wdata);
					REG_CENTER_Y:  center_y_q  <= signed'(cfg_wdata);
					REG_CENTER_Z:  center_z_q  <= signed'(cfg_wdata);
					REG_PLANE_COS: plane_cos_q <= signed'(cfg_wdata[17:0]);
					REG_PLANE_SIN: plane_sin_q <= signed'(cfg_wdata[17:0]);
					default: ;
				endcase
			end
		end
	end

	assign busy = busy_q;

	// velocity and acceleration amplitudes, rounded to Q16
	logic [39:0] rw_full;
	logic [44:0] rww_full;
	always_comb begin
		rw_full  = 40'(radius_q) * 40'(rate_q) + 40'd32768;
		rww_full = 45'(rw_q) * 45'(rate_q) + 45'd32768;
	end

	always_ff @(posedge clk) begin
		rw_q  <= rw_full[39:16];
		rww_q <= rww_full[43:16];
	end

	// ---------------- stage 1: phase product ----------------
	logic        vld_s1;
	logic [51:0] prod_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else
			vld_s1 <= start && !busy_q;
	end

	always_ff @(posedge clk) begin
		prod_s1 <= 52'(rate_q) * 52'(elapsed_time);
	end

	// ---------------- modulo 2*pi, restoring, three bits a stage ----------------
	logic                mod_vld_s [MOD_ST+1];
	logic [27:0]         mod_rem_s [MOD_ST+1];
	logic [MOD_BITS-1:0] mod_lo_s  [MOD_ST+1];

	assign mod_vld_s[0] = vld_s1;
	assign mod_rem_s[0] = {2'b00, prod_s1[51:26]};
	assign mod_lo_s[0]  = prod_s1[25:8];

	for (genvar g = 0; g < MOD_ST; g++) begin : g_mod
		logic [27:0]         r;
		logic [MOD_BITS-1:0] lo;
		always_comb begin
			r  = mod_rem_s[g];
			lo = mod_lo_s[g];
			for (int j = 0; j < MOD_PER; j++) begin
				r  = {r[26:0], lo[MOD_BITS-1]};
				lo = {lo[MOD_BITS-2:0], 1'b0};
				if (r >= TWO_PI_Q24)
					r = r - TWO_PI_Q24;
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				mod_vld_s[g+1] <= 1'b0;
			else
				mod_vld_s[g+1] <= mod_vld_s[g];
		end
		always_ff @(posedge clk) begin
			mod_rem_s[g+1] <= r;
			mod_lo_s[g+1]  <= lo;
		end
	end

	// ---------------- fold into +-pi/2 ----------------
	logic               cvld_s [CS+1];
	logic signed [27:0] cx_s   [CS+1];
	logic signed [27:0] cy_s   [CS+1];
	logic signed [27:0] cz_s   [CS+1];
	logic               cneg_s [CS+1];

	logic signed [27:0] fz0, fz;
	logic               fneg;
	always_comb begin
		fz0  = signed'(mod_rem_s[MOD_ST]);
		if (fz0 > PI_Q24)
			fz0 = fz0 - signed'(TWO_PI_Q24);
		fz   = fz0;
		fneg = 1'b0;
		if (fz0 > HALF_PI_Q24) begin
			fz   = fz0 - PI_Q24;
			fneg = 1'b1;
		end else if (fz0 < -HALF_PI_Q24) begin
			fz   = fz0 + PI_Q24;
			fneg = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cvld_s[0] <= 1'b0;
		else
			cvld_s[0] <= mod_vld_s[MOD_ST];
	end

	always_ff @(posedge clk) begin
		cx_s[0]   <= CORDIC_GAIN_Q24;
		cy_s[0]   <= '0;
		cz_s[0]   <= fz;
		cneg_s[0] <= fneg;
	end

	// ---------------- CORDIC, one iteration a stage ----------------
	for (genvar g = 0; g < CS; g++) begin : g_cordic
		logic signed [27:0] dx, dy, at;
		always_comb begin
			dx = cy_s[g] >>> g;
			dy = cx_s[g] >>> g;
			at = atan_q24(5'(g));
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				cvld_s[g+1] <= 1'b0;
			else
				cvld_s[g+1] <= cvld_s[g];
		end
		always_ff @(posedge clk) begin
			cneg_s[g+1] <= cneg_s[g];
			if (cz_s[g] >= 0) begin
				cx_s[g+1] <= cx_s[g] - dx;
				cy_s[g+1] <= cy_s[g] + dy;
				cz_s[g+1] <= cz_s[g] - at;
			end else begin
				cx_s[g+1] <= cx_s[g] + dx;
				cy_s[g+1] <= cy_s[g] - dy;
				cz_s[g+1] <= cz_s[g] + at;
			end
		end
	end

	// ---------------- M1: planar products ----------------
	logic signed [27:0] tc, ts, tnc, tns;
	logic signed [19:0] r_sg;
	logic signed [24:0] rw_sg;
	logic signed [28:0] rww_sg;
	always_comb begin
		tc     = cneg_s[CS] ? -cx_s[CS] : cx_s[CS];
		ts     = cneg_s[CS] ? -cy_s[CS] : cy_s[CS];
		tnc    = -tc;
		tns    = -ts;
		r_sg   = signed'({1'b0, radius_q});
		rw_sg  = signed'({1'b0, rw_q});
		rww_sg = signed'({1'b0, rww_q});
	end

	logic               vld_m1;
	logic signed [55:0] p_s_m1 [6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_m1 <= 1'b0;
		else
			vld_m1 <= cvld_s[CS];
	end

	always_ff @(posedge clk) begin
		p_s_m1[0] <= r_sg * tc;     // pos a
		p_s_m1[1] <= r_sg * ts;     // pos b
		p_s_m1[2] <= rw_sg * tns;   // vel a
		p_s_m1[3] <= rw_sg * tc;    // vel b
		p_s_m1[4] <= rww_sg * tnc;  // acc a
		p_s_m1[5] <= rww_sg * tns;  // acc b
	end

	// ---------------- M2: round to Q16 ----------------
	logic               vld_m2;
	logic signed [31:0] ab_m2 [6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_m2 <= 1'b0;
		else
			vld_m2 <= vld_m1;
	end

	for (genvar k = 0; k < 6; k++) begin : g_rnd24
		logic signed [55:0] t;
		always_comb t = (p_s_m1[k] + 56'sd8388608) >>> 24;
		always_ff @(posedge clk) ab_m2[k] <= t[31:0];
	end

	// ---------------- M3: tilt about y ----------------
	logic               vld_m3;
	logic signed [49:0] px_m3 [3];
	logic signed [49:0] pz_m3 [3];
	logic signed [31:0] py_m3 [3];
	logic signed [18:0] nps;

	always_comb nps = -(19'(plane_sin_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_m3 <= 1'b0;
		else
			vld_m3 <= vld_m2;
	end

	for (genvar k = 0; k < 3; k++) begin : g_tilt
		always_ff @(posedge clk) begin
			px_m3[k] <= plane_cos_q * ab_m2[2*k];
			pz_m3[k] <= nps * ab_m2[2*k];
			py_m3[k] <= ab_m2[2*k+1];
		end
	end

	// ---------------- M4: round, offset, saturate ----------------
	logic signed [SAT_W-1:0] ox [3];
	logic signed [SAT_W-1:0] oy [3];
	logic signed [SAT_W-1:0] oz [3];
	logic signed [49:0]      rx [3];
	logic signed [49:0]      rz [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			rx[k] = (px_m3[k] + 50'sd32768) >>> 16;
			rz[k] = (pz_m3[k] + 50'sd32768) >>> 16;
			ox[k] = SAT_W'(rx[k]);
			oz[k] = SAT_W'(rz[k]);
			oy[k] = SAT_W'(py_m3[k]);
		end
		ox[0] = ox[0] + SAT_W'(center_x_q);
		oy[0] = oy[0] + SAT_W'(center_y_q);
		oz[0] = oz[0] + SAT_W'(center_z_q);
	end

	logic done_m4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_m4 <= 1'b0;
		else
			done_m4 <= vld_m3;
	end

	always_ff @(posedge clk) begin
		pos_x <= sat_out(ox[0]);
		pos_y <= sat_out(oy[0]);
		pos_z <= sat_out(oz[0]);
		vel_x <= sat_out(ox[1]);
		vel_y <= sat_out(oy[1]);
		vel_z <= sat_out(oz[1]);
		acc_x <= sat_out(ox[2]);
		acc_y <= sat_out(oy[2]);
		acc_z <= sat_out(oz[2]);
	end

	assign done = done_m4;

	// ---------------- assertions ----------------
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("result beat missing at pipeline latency");

	a_mod_range: assert property (@(posedge clk) disable iff (!arst_n)
		mod_vld_s[MOD_ST] |-> (mod_rem_s[MOD_ST] < TWO_PI_Q24))
		else $error("phase residue not reduced below 2*pi");

	a_fold_range: assert property (@(posedge clk) disable iff (!arst_n)
		cvld_s[0] |-> (cz_s[0] <= HALF_PI_Q24 && cz_s[0] >= -HALF_PI_Q24))
		else $error("folded phase outside +-pi/2");

	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(cvld_s[CS], 4))
		else $error("result beat without a CORDIC result four cycles earlier");

endmodule
`default_nettype wire
